@@ hdl/sidta_pkg.sv @@
// Shared types and constants for the signed integer to decimal ASCII converter.
package sidta_pkg;

    localparam int unsigned VALUE_W         = 32;
    localparam int unsigned CHAR_W          = 6;
    localparam int unsigned NUM_DIGITS      = 10;
    localparam int unsigned BCD_W           = 4 * NUM_DIGITS;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_item;

endpackage

@@ hdl/sidta_front.sv @@
// Input stage: accepts a value beat, splits it into sign and magnitude.
module sidta_front
    import sidta_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output t_item              o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.neg = i_value[VALUE_W-1];
        n_item.mag = i_value[VALUE_W-1] ? (~i_value + {{(VALUE_W-1){1'b0}}, 1'b1}) : i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

@@ hdl/sidta_queue.sv @@
// Short register FIFO between the input stage and the conversion engine.
module sidta_queue
    import sidta_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             wr;
    logic             rd;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

@@ hdl/sidta_back.sv @@
// Conversion engine: shift-add-3 binary to BCD, then one character beat per cycle while the output is not stalled.
module sidta_back
    import sidta_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_item             i_item,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_FIND = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam int unsigned STEP_W = $clog2(VALUE_W + 1);
    localparam int unsigned IDX_W  = $clog2(NUM_DIGITS);

    logic [1:0]         r_state;
    logic [STEP_W-1:0]  r_steps;
    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [IDX_W-1:0]   r_idx;
    logic               r_sign;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    logic [BCD_W-1:0]   adj_bcd;
    logic [IDX_W-1:0]   msd_idx;
    logic [3:0]         cur_digit;
    logic               out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign o_tvalid = r_out_valid;
    assign o_char   = r_char;
    assign o_last   = r_last;
    assign out_free = !r_out_valid || i_tready;

    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            adj_bcd[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                            : r_bcd[4*d +: 4];
        end
    end

    always_comb begin
        msd_idx = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0) begin
                msd_idx = IDX_W'(d);
            end
        end
    end

    assign cur_digit = r_bcd[4*r_idx +: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (r_steps == STEP_W'(1)) begin
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (!r_sign && r_idx == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_bin   <= i_item.mag;
                r_sign  <= i_item.neg;
                r_bcd   <= '0;
                r_steps <= STEP_W'(VALUE_W);
            end
            S_CONV: begin
                {r_bcd, r_bin} <= {adj_bcd[BCD_W-2:0], r_bin, 1'b0};
                r_steps        <= r_steps - 1'b1;
            end
            S_FIND: begin
                r_idx <= msd_idx;
            end
            S_EMIT: begin
                if (out_free) begin
                    if (r_sign) begin
                        r_char <= CHAR_MINUS;
                        r_last <= 1'b0;
                        r_sign <= 1'b0;
                    end else begin
                        r_char <= CHAR_ZERO + {2'b00, cur_digit};
                        r_last <= (r_idx == '0);
                        r_idx  <= r_idx - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_char == CHAR_MINUS
                         || (r_char >= CHAR_ZERO && r_char <= CHAR_ZERO + 6'd9)))
        else $error("character out of range");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_char == CHAR_MINUS) |-> !r_last)
        else $error("minus sign marked last");

    a_conv_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && $past(r_state) == S_CONV) |-> r_steps == $past(r_steps) - 1'b1)
        else $error("conversion step count slipped");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && !r_sign && r_idx == '0) |=> r_state == S_IDLE && r_last)
        else $error("final digit not marked");
`endif

endmodule

@@ hdl/signed_int_to_decimal_ascii.sv @@
// Top level: signed 32-bit integer to decimal ASCII character stream.
// Each value beat becomes a run of character beats: '-' for a negative value, then the
// decimal digits most significant first without leading zeros ('0' for zero); tlast marks
// the final character. Each item is loaded, run through the 32-step shift-add-3 loop in
// the conversion engine and scanned for its leading digit, then sent as one output beat
// per character. A small queue behind the input stage holds further values while a
// conversion runs, and the output register lets the next conversion start while the
// last character still waits.
module signed_int_to_decimal_ascii
    import sidta_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [5:0] character, [7:6] zero
    output logic        o_m_tlast    // last_char
);

    logic        f_valid;
    logic        f_ready;
    t_item       f_item;
    logic        q_valid;
    logic        q_ready;
    t_item       q_item;
    logic [CHAR_W-1:0] b_char;

    sidta_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_value (i_s_tdata),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    sidta_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    sidta_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_item   (q_item),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_char   (b_char),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, b_char};

endmodule

@@ test/signed_int_to_decimal_ascii_tb.sv @@
// Testbench for the signed integer to decimal ASCII converter: directed table, then random values.
module signed_int_to_decimal_ascii_tb
    import sidta_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DIR_COUNT   = 22;
    localparam int          RAND_COUNT  = 138;
    localparam int          MAX_IDLE    = 18;
    localparam int          TAIL_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_beat;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    t_char_beat  pending_chars[$];
    string       value_text_q[$];
    int          mismatch_count;
    int unsigned cycle_count;
    bit          no_idle;

    int dir_value[DIR_COUNT] = '{
        0, 1, -1, 7, -5, 9, 10, -10, 99, 100,
        2147483647, -2147483647, 32'h8000_0000, 1000000000, 999999999, -999999999,
        1234567890, -123456789, 32'h5555_5555, 32'hAAAA_AAAA, -1000000000, 65536
    };
    string dir_text[DIR_COUNT] = '{
        "0", "1", "-1", "", "", "", "", "", "", "",
        "2147483647", "", "-2147483648", "", "", "",
        "", "", "", "", "", ""
    };

    signed_int_to_decimal_ascii dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // [31:0] value
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // [5:0] character, [7:6] zero
        .o_m_tlast  (m_tlast)     // last_char
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void push_text(input string txt);
        for (int k = 0; k < txt.len(); k++) begin
            byte c;
            c = txt[k];
            pending_chars.push_back('{ch: c[CHAR_W-1:0], last: (k == txt.len() - 1)});
        end
    endfunction

    function automatic void predict_text(input logic [31:0] value);
        logic [31:0] mag;
        logic [3:0]  digits[10];
        int          n;
        n = 0;
        mag = value[31] ? (~value + 32'd1) : value;
        if (value[31]) begin
            pending_chars.push_back('{ch: CHAR_MINUS, last: 1'b0});
        end
        do begin
            digits[n] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            n++;
        end while (mag != 0);
        for (int k = n - 1; k >= 0; k--) begin
            pending_chars.push_back('{ch: CHAR_ZERO + CHAR_W'(digits[k]), last: (k == 0)});
        end
    endfunction

    function automatic logic [31:0] random_value();
        longint mag;
        longint scale;
        int     kind;
        int     digits;
        kind = $urandom_range(0, 9);
        mag = 0;
        case (kind)
            0, 1, 2, 3: begin
                return $urandom;
            end
            4, 5, 6: begin
                digits = $urandom_range(1, 10);
                scale = 1;
                repeat (digits) scale = scale * 10;
                mag = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % scale;
            end
            7: begin
                scale = 1;
                repeat ($urandom_range(0, 9)) scale = scale * 10;
                mag = scale + $signed($urandom_range(0, 2)) - 1;
            end
            8: begin
                mag = $urandom_range(0, 20);
            end
            default: begin
                mag = 64'd2147483648 - $urandom_range(0, 3);
            end
        endcase
        return ($urandom_range(0, 1) == 1) ? 32'(-mag) : 32'(mag);
    endfunction

    task automatic send_value(input logic [31:0] value, input string txt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        value_text_q.push_back(txt);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Prediction on input acceptance, checking on output acceptance.
    always @(posedge clk) begin
        string      txt;
        t_char_beat want;
        if (rst_n && s_tvalid && s_tready) begin
            txt = value_text_q.pop_front();
            if (txt.len() != 0) begin
                push_text(txt);
            end else begin
                predict_text(s_tdata);
            end
        end
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                $error("character: no beat expected, got %0d", m_tdata[CHAR_W-1:0]);
                mismatch_count++;
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata[CHAR_W-1:0] !== want.ch) begin
                    $error("character: expected %0d, got %0d", want.ch, m_tdata[CHAR_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[7:CHAR_W] !== '0) begin
                    $error("pad: expected 0, got %0d", m_tdata[7:CHAR_W]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_char: expected %0d, got %0d", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("signed_int_to_decimal_ascii_tb failed");
            $finish;
        end
    end

    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial begin
        mismatch_count = 0;
        cycle_count    = 0;
        no_idle        = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_COUNT; i++) begin
            send_value(32'(dir_value[i]), dir_text[i]);
        end

        for (int i = 0; i < RAND_COUNT; i++) begin
            no_idle = ((i / 40) % 2) == 1;
            if (i == 100) begin
                s_tvalid <= 1'b0;
                do @(posedge clk); while (pending_chars.size() != 0);
            end
            send_value(random_value(), "");
        end

        s_tvalid <= 1'b0;
        no_idle = 1'b0;
        do @(posedge clk); while (pending_chars.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending_chars.size() != 0) begin
            $error("character: %0d beats never arrived", pending_chars.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("signed_int_to_decimal_ascii_tb passed");
        end else begin
            $display("signed_int_to_decimal_ascii_tb failed");
        end
        $finish;
    end

endmodule
